### sv/omip_pkg.sv
// Shared types, constants and helpers for the orthogonal max intensity projection.
// No dependencies; imported by every module of the block except omip_ram.
package omip_pkg;

  // Fixed field widths
  localparam int CFG_W  = 10;
  localparam int IDX_W  = 9;
  localparam int VAL_W  = 8;
  localparam int VIEW_W = 2;
  localparam int REG_W  = 2;

  // Default volume capacity
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_MAX_DEPTH  = 512;

  // Register indexes
  localparam logic [REG_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [REG_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [REG_W-1:0] REG_DEPTH  = 2'd2;

  // Projection codes
  localparam logic [VIEW_W-1:0] VIEW_XY = 2'd0;
  localparam logic [VIEW_W-1:0] VIEW_XZ = 2'd1;
  localparam logic [VIEW_W-1:0] VIEW_YZ = 2'd2;

  // Packet queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // All results caused by one voxel; mask bit 0 XY, 1 XZ, 2 YZ
  typedef struct packed {
    logic [2:0]       mask;
    logic             eov;
    logic [IDX_W-1:0] x;
    logic [IDX_W-1:0] y;
    logic [IDX_W-1:0] z;
    logic [VAL_W-1:0] m_xy;
    logic [VAL_W-1:0] m_xz;
    logic [VAL_W-1:0] m_yz;
  } pkt_t;

  // Last position for a register value: 0 acts as 1, above cap acts as cap
  function automatic int unsigned limit_m1(logic [CFG_W-1:0] v, int unsigned cap);
    int unsigned r;
    if (v == '0) r = 0;
    else if (int'(v) > int'(cap)) r = cap - 1;
    else r = int'(v) - 1;
    return r;
  endfunction

endpackage

### sv/omip_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
module omip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  clk,
  we,
  waddr,
  wdata,
  re,
  raddr,
  rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk;
  input  logic             we;
  input  logic [AW-1:0]    waddr;
  input  logic [WIDTH-1:0] wdata;
  input  logic             re;
  input  logic [AW-1:0]    raddr;
  output logic [WIDTH-1:0] rdata;

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

### sv/omip_front.sv
// Front: voxel intake, raster counters, limits, store read-modify-write, packet build.
// Depends on omip_pkg and omip_ram.
module omip_front #(
  parameter int MAX_WIDTH  = omip_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = omip_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_DEPTH  = omip_pkg::DEF_MAX_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [omip_pkg::VAL_W-1:0] voxel_value,
  output logic                       full,
  input  logic                       cfg_valid,
  input  logic [omip_pkg::REG_W-1:0] cfg_index,
  input  logic [omip_pkg::CFG_W-1:0] cfg_data,
  input  logic [omip_pkg::QCW-1:0]   q_count,
  output logic                       pkt_valid,
  output omip_pkg::pkt_t             pkt
);
  import omip_pkg::*;

  localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ZW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int FD  = MAX_WIDTH * MAX_HEIGHT;
  localparam int FAW = (FD > 1) ? $clog2(FD) : 1;

  // limit registers hold last position (limit minus one)
  logic [XW-1:0] x_m1;
  logic [YW-1:0] y_m1;
  logic [ZW-1:0] z_m1;

  logic [XW-1:0] pos_x;
  logic [YW-1:0] pos_y;
  logic [ZW-1:0] pos_z;

  logic           accept;
  logic           lx, ly, lz;
  logic [FAW-1:0] s0_fa;

  // stage 1 registers
  logic             s1_valid;
  logic [VAL_W-1:0] s1_v;
  logic [XW-1:0]    s1_x;
  logic [YW-1:0]    s1_y;
  logic [ZW-1:0]    s1_z;
  logic             s1_lx, s1_ly, s1_lz;
  logic [FAW-1:0]   s1_fa;
  logic             s1_has;

  // bypass of the write done in the previous cycle
  logic             fwd_valid;
  logic [FAW-1:0]   fwd_f_addr;
  logic [VAL_W-1:0] fwd_f_data;
  logic [XW-1:0]    fwd_r_addr;
  logic [VAL_W-1:0] fwd_r_data;

  logic [VAL_W-1:0] row_running_max;
  logic [VAL_W-1:0] f_rdata, r_rdata;
  logic [VAL_W-1:0] fd, rd;
  logic [VAL_W-1:0] m_xy, m_xz, m_yz;
  logic [QCW:0]     used;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_m1 <= XW'(limit_m1(10'd512, MAX_WIDTH));
      y_m1 <= YW'(limit_m1(10'd512, MAX_HEIGHT));
      z_m1 <= ZW'(limit_m1(10'd512, MAX_DEPTH));
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  x_m1 <= XW'(limit_m1(cfg_data, MAX_WIDTH));
        REG_HEIGHT: y_m1 <= YW'(limit_m1(cfg_data, MAX_HEIGHT));
        REG_DEPTH:  z_m1 <= ZW'(limit_m1(cfg_data, MAX_DEPTH));
        default: ;
      endcase
    end
  end

  // room check counts the packet still in stage 1
  assign s1_has = s1_valid && (s1_lx || s1_ly || s1_lz);
  assign used   = (QCW+1)'(q_count) + (QCW+1)'(s1_has);
  assign full   = (used >= (QCW+1)'(QDEPTH));
  assign accept = push && !full;

  assign lx    = (pos_x >= x_m1);
  assign ly    = (pos_y >= y_m1);
  assign lz    = (pos_z >= z_m1);
  assign s0_fa = FAW'(FAW'(pos_y) * FAW'(MAX_WIDTH) + FAW'(pos_x));

  // raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (accept) begin
      if (!lx) begin
        pos_x <= pos_x + 1'b1;
      end else begin
        pos_x <= '0;
        if (!ly) begin
          pos_y <= pos_y + 1'b1;
        end else begin
          pos_y <= '0;
          pos_z <= lz ? '0 : pos_z + 1'b1;
        end
      end
    end
  end

  // stage 1 capture
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= accept;
    s1_v  <= voxel_value;
    s1_x  <= pos_x;
    s1_y  <= pos_y;
    s1_z  <= pos_z;
    s1_lx <= lx;
    s1_ly <= ly;
    s1_lz <= lz;
    s1_fa <= s0_fa;
  end

  omip_ram #(.WIDTH(VAL_W), .DEPTH(FD)) u_frame (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_fa),
    .wdata (m_xy),
    .re    (accept),
    .raddr (s0_fa),
    .rdata (f_rdata)
  );

  omip_ram #(.WIDTH(VAL_W), .DEPTH(MAX_WIDTH)) u_row (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_x),
    .wdata (m_xz),
    .re    (accept),
    .raddr (pos_x),
    .rdata (r_rdata)
  );

  // merge with stored maxima; first slice/row/voxel takes the value directly
  assign fd   = (fwd_valid && fwd_f_addr == s1_fa) ? fwd_f_data : f_rdata;
  assign rd   = (fwd_valid && fwd_r_addr == s1_x) ? fwd_r_data : r_rdata;
  assign m_xy = (s1_z == '0 || fd < s1_v) ? s1_v : fd;
  assign m_xz = (s1_y == '0 || rd < s1_v) ? s1_v : rd;
  assign m_yz = (s1_x == '0 || row_running_max < s1_v) ? s1_v : row_running_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid       <= 1'b0;
      row_running_max <= '0;
    end else begin
      fwd_valid <= s1_valid;
      if (s1_valid) row_running_max <= m_yz;
    end
    fwd_f_addr <= s1_fa;
    fwd_f_data <= m_xy;
    fwd_r_addr <= s1_x;
    fwd_r_data <= m_xz;
  end

  // packet toward the queue
  assign pkt_valid = s1_has;
  always_comb begin
    pkt.mask = {s1_lx, s1_ly, s1_lz};
    pkt.eov  = s1_lx && s1_ly && s1_lz;
    pkt.x    = IDX_W'(s1_x);
    pkt.y    = IDX_W'(s1_y);
    pkt.z    = IDX_W'(s1_z);
    pkt.m_xy = m_xy;
    pkt.m_xz = m_xz;
    pkt.m_yz = m_yz;
  end

endmodule

### sv/omip_queue.sv
// Short packet queue between front and back.
// Depends on omip_pkg.
module omip_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  omip_pkg::pkt_t           push_pkt,
  input  logic                     pop,
  output omip_pkg::pkt_t           head,
  output logic                     not_empty,
  output logic [omip_pkg::QCW-1:0] count
);
  import omip_pkg::*;

  pkt_t           entries [QDEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);

  // pointers and occupancy; front guarantees room
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_pkt;
  end

endmodule

### sv/omip_back.sv
// Back: unpacks one packet into its results, oldest first, in XY, XZ, YZ order.
// Depends on omip_pkg.
module omip_back (
  input  logic                        clk,
  input  logic                        rst,
  input  omip_pkg::pkt_t              q_head,
  input  logic                        q_not_empty,
  output logic                        q_pop,
  output logic                        empty,
  input  logic                        pop,
  output logic [omip_pkg::VIEW_W-1:0] view,
  output logic [omip_pkg::IDX_W-1:0]  col_index,
  output logic [omip_pkg::IDX_W-1:0]  row_index,
  output logic [omip_pkg::VAL_W-1:0]  max_value,
  output logic                        last_of_run,
  output logic                        end_of_volume
);
  import omip_pkg::*;

  pkt_t       hold;
  logic [2:0] mask;
  logic [2:0] sel;
  logic [2:0] rest;
  logic [2:0] mask_next;
  logic       take;

  assign empty = (mask == '0);
  assign sel   = mask & (~mask + 3'd1);
  assign rest  = mask & ~sel;
  assign take  = !empty && pop;
  // reload when nothing will be left showing
  assign q_pop = q_not_empty && (empty || (take && rest == '0));

  always_comb begin
    mask_next = mask;
    if (take) mask_next = rest;
    if (q_pop) mask_next = q_head.mask;
  end

  always_ff @(posedge clk) begin
    if (rst) mask <= '0;
    else mask <= mask_next;
    if (q_pop) hold <= q_head;
  end

  // result fields for the lowest pending view
  always_comb begin
    if (sel[0]) begin
      view      = VIEW_XY;
      col_index = hold.x;
      row_index = hold.y;
      max_value = hold.m_xy;
    end else if (sel[1]) begin
      view      = VIEW_XZ;
      col_index = hold.x;
      row_index = hold.z;
      max_value = hold.m_xz;
    end else begin
      view      = VIEW_YZ;
      col_index = hold.y;
      row_index = hold.z;
      max_value = hold.m_yz;
    end
    last_of_run   = (rest == '0);
    end_of_volume = (rest == '0) && hold.eov;
  end

endmodule

### sv/orthogonal_max_intensity_projection_top.sv
// A voxel's first result shows once it has passed stage 1, the packet queue and the back's hold register.
// Throughput: one voxel per cycle while full is low; results leave one per pop, a voxel
// yielding up to three, so the output port and the four-packet queue set the sustained rate.
// Reset clears counters and queue, sets all limits to 512 (capped at MAX_*); the frame and row stores
// are not cleared and need no pass after reset.
module orthogonal_max_intensity_projection_top #(
  parameter int MAX_WIDTH  = omip_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = omip_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_DEPTH  = omip_pkg::DEF_MAX_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [omip_pkg::VAL_W-1:0]  voxel_value,
  output logic                        empty,
  input  logic                        pop,
  output logic [omip_pkg::VIEW_W-1:0] view,
  output logic [omip_pkg::IDX_W-1:0]  col_index,
  output logic [omip_pkg::IDX_W-1:0]  row_index,
  output logic [omip_pkg::VAL_W-1:0]  max_value,
  output logic                        last_of_run,
  output logic                        end_of_volume,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [omip_pkg::REG_W-1:0]  cfg_index,
  input  logic [omip_pkg::CFG_W-1:0]  cfg_data
);
  import omip_pkg::*;

  logic           pkt_valid;
  pkt_t           pkt;
  pkt_t           q_head;
  logic           q_not_empty;
  logic           q_pop;
  logic [QCW-1:0] q_count;

  assign cfg_ready = 1'b1;

  omip_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .voxel_value (voxel_value),
    .full        (full),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_count     (q_count),
    .pkt_valid   (pkt_valid),
    .pkt         (pkt)
  );

  omip_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (pkt_valid),
    .push_pkt  (pkt),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  omip_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_head        (q_head),
    .q_not_empty   (q_not_empty),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .view          (view),
    .col_index     (col_index),
    .row_index     (row_index),
    .max_value     (max_value),
    .last_of_run   (last_of_run),
    .end_of_volume (end_of_volume)
  );

endmodule
